FILE: design/mbe_pkg.sv
// ---------------------------------------------------------------------------
// mbe_pkg: shared types and constants of the escape-time engine
// fixed-point formats, register indexes, reset values and the cell token
// ---------------------------------------------------------------------------
package mbe_pkg;

   // fixed-point and field widths
   localparam int FRAC_BITS  = 28;
   localparam int INDEX_BITS = 12;
   localparam int ITER_BITS  = 16;
   localparam int COORD_BITS = 32;

   // magnitude of a z component that is still squared (below 2.0)
   localparam int MAG_BITS  = FRAC_BITS + 1;
   localparam int PROD_BITS = 2 * MAG_BITS;
   // truncated square, below 4.0
   localparam int SQ_BITS   = PROD_BITS - FRAC_BITS;
   // doubled cross term, below 8.0
   localparam int XT_BITS   = PROD_BITS - FRAC_BITS + 1;

   // width of c and z: holds c plus a bounded update with margin
   localparam int C_RAW_BITS = INDEX_BITS + COORD_BITS + 1;
   localparam int Z_BITS     = ((C_RAW_BITS > XT_BITS) ? C_RAW_BITS : XT_BITS) + 2;

   // number of iteration cells in the ring
   localparam int NUM_CELLS = 4;

   // configuration port
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = COORD_BITS;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_X_LEFT   = 3'd0,
      REG_Y_BOTTOM = 3'd1,
      REG_STEP_X   = 3'd2,
      REG_STEP_Y   = 3'd3,
      REG_MAX_ITER = 3'd4
   } reg_index_type;

   // register reset values
   localparam logic signed [COORD_BITS-1:0] X_LEFT_RST   = 32'shE000_0000;
   localparam logic signed [COORD_BITS-1:0] Y_BOTTOM_RST = 32'shE800_0000;
   localparam logic signed [COORD_BITS-1:0] STEP_X_RST   = 32'sd786432;
   localparam logic signed [COORD_BITS-1:0] STEP_Y_RST   = 32'sd786432;
   localparam logic [ITER_BITS-1:0]         MAX_ITER_RST = 16'd255;

   // top-level sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MULT,
      ST_SEED,
      ST_RUN
   } state_type;

   // token handed from cell to cell: one pixel's iteration state
   typedef struct packed {
      logic                     valid;
      logic                     done;
      logic                     in_set;
      logic [ITER_BITS-1:0]     count;
      logic signed [Z_BITS-1:0] zr;
      logic signed [Z_BITS-1:0] zi;
   } token_type;

   // middle register of a cell: token control plus the three products
   typedef struct packed {
      logic                 valid;
      logic                 done;
      logic                 in_set;
      logic [ITER_BITS-1:0] count;
      logic                 neg_x;
      logic [PROD_BITS-1:0] pr;
      logic [PROD_BITS-1:0] pi;
      logic [PROD_BITS-1:0] px;
   } prod_type;

endpackage

FILE: design/mbe_cell.sv
// ---------------------------------------------------------------------------
// mbe_cell: one iteration cell of the ring
// does z = z*z + c on the token it receives in two register stages:
// limit and bound checks and products, then escape test and update
// ---------------------------------------------------------------------------
module mbe_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [mbe_pkg::ITER_BITS-1:0]    limit,
   input  logic signed [mbe_pkg::Z_BITS-1:0] cr,
   input  logic signed [mbe_pkg::Z_BITS-1:0] ci,
   input  mbe_pkg::token_type               tok_in,
   output mbe_pkg::token_type               tok_out
);
   import mbe_pkg::*;

   localparam logic signed [Z_BITS-1:0] TWO     = Z_BITS'(1) <<< (FRAC_BITS + 1);
   localparam logic signed [Z_BITS-1:0] NEG_TWO = -TWO;

   prod_type  a_ff, a_in;
   token_type b_ff, b_in;

   logic              big;
   logic [Z_BITS-1:0] zr_abs, zi_abs;
   logic [MAG_BITS-1:0] mag_r, mag_i;

   logic [SQ_BITS-1:0]  sr, si;
   logic [SQ_BITS:0]    sq_sum;
   logic [XT_BITS-1:0]  cross_mag;
   logic signed [Z_BITS-1:0] cross_ext, cross_sgn, nr, ni;

   // stage a: limit and bound checks, magnitudes and products
   always_comb begin
      big = (tok_in.zr >= TWO) || (tok_in.zr <= NEG_TWO) ||
            (tok_in.zi >= TWO) || (tok_in.zi <= NEG_TWO);
      zr_abs = tok_in.zr[Z_BITS-1] ? (~tok_in.zr + 1'b1) : tok_in.zr;
      zi_abs = tok_in.zi[Z_BITS-1] ? (~tok_in.zi + 1'b1) : tok_in.zi;
      mag_r  = zr_abs[MAG_BITS-1:0];
      mag_i  = zi_abs[MAG_BITS-1:0];

      a_in.valid  = tok_in.valid;
      a_in.done   = tok_in.done;
      a_in.in_set = tok_in.in_set;
      a_in.count  = tok_in.count;
      a_in.neg_x  = tok_in.zr[Z_BITS-1] ^ tok_in.zi[Z_BITS-1];
      a_in.pr     = mag_r * mag_r;
      a_in.pi     = mag_i * mag_i;
      a_in.px     = mag_r * mag_i;
      if (tok_in.valid && !tok_in.done) begin
         if (tok_in.count >= limit) begin
            a_in.done   = 1'b1;
            a_in.in_set = 1'b1;
         end else if (big) begin
            a_in.done   = 1'b1;
            a_in.in_set = 1'b0;
         end
      end
   end

   // stage b: escape test on the truncated squares, then the new z
   always_comb begin
      sr        = a_ff.pr[PROD_BITS-1:FRAC_BITS];
      si        = a_ff.pi[PROD_BITS-1:FRAC_BITS];
      sq_sum    = {1'b0, sr} + {1'b0, si};
      cross_mag = a_ff.px[PROD_BITS-1:FRAC_BITS-1];
      cross_ext = $signed({{(Z_BITS-XT_BITS){1'b0}}, cross_mag});
      cross_sgn = a_ff.neg_x ? -cross_ext : cross_ext;
      nr = $signed({{(Z_BITS-SQ_BITS){1'b0}}, sr}) -
           $signed({{(Z_BITS-SQ_BITS){1'b0}}, si}) + cr;
      ni = cross_sgn + ci;

      b_in.valid  = a_ff.valid;
      b_in.done   = a_ff.done;
      b_in.in_set = a_ff.in_set;
      b_in.count  = a_ff.count;
      b_in.zr     = nr;
      b_in.zi     = ni;
      if (a_ff.valid && !a_ff.done) begin
         // sum at or above 4.0 sets the top bit
         if (sq_sum[SQ_BITS]) begin
            b_in.done   = 1'b1;
            b_in.in_set = 1'b0;
         end else begin
            b_in.count = a_ff.count + 1'b1;
         end
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= '0;
         b_ff <= '0;
      end else begin
         a_ff <= a_in;
         b_ff <= b_in;
      end
   end

   assign tok_out = b_ff;

endmodule

FILE: design/mandelbrot_escape_time.sv
// ---------------------------------------------------------------------------
// mandelbrot_escape_time: escape-time pixel engine
// forms c from a pixel index and iterates z = z*z + c in a ring of cells
// ---------------------------------------------------------------------------
//
//   channel  ports                                  handshake
//   -------  -------------------------------------  -----------------------
//   request  start, req_column, req_row             start high, busy low
//   result   rsp_valid, rsp_count, rsp_inside_res   one-cycle strobe
//   config   csr_we, csr_index, csr_wdata           write when csr_we high
//
// one pixel at a time; busy is high from acceptance until the result strobe.
// each iteration passes through the stage registers of a cell, and a finished
// word is seen only where the ring wraps. c is registered as index times step,
// then as that product plus the origin (multiply, then add).
// reset returns the configuration registers to their defaults and empties the ring.
// the receiver cannot stall; each result shows for exactly one cycle.
//
module mandelbrot_escape_time (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [mbe_pkg::INDEX_BITS-1:0]      req_column,
   input  logic [mbe_pkg::INDEX_BITS-1:0]      req_row,
   output logic                                rsp_valid,
   output logic [mbe_pkg::ITER_BITS-1:0]       rsp_count,
   output logic                                rsp_inside_res,
   input  logic                                csr_we,
   input  logic [mbe_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [mbe_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import mbe_pkg::*;

   localparam int MP_BITS = INDEX_BITS + COORD_BITS + 1;

   logic signed [COORD_BITS-1:0] x_left_ff, y_bottom_ff, step_x_ff, step_y_ff;
   logic [ITER_BITS-1:0]         max_iter_ff;

   state_type state_ff, state_in;
   logic [INDEX_BITS-1:0] col_ff, col_in, row_ff, row_in;
   logic signed [MP_BITS-1:0] prod_x_ff, prod_y_ff;
   logic signed [Z_BITS-1:0]  cr_ff, ci_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ITER_BITS-1:0]  rsp_count_ff, rsp_count_in;
   logic                  rsp_inside_ff, rsp_inside_in;

   token_type tok [NUM_CELLS+1];
   token_type seed_tok;
   logic      seed;
   token_type ring_out;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         x_left_ff   <= X_LEFT_RST;
         y_bottom_ff <= Y_BOTTOM_RST;
         step_x_ff   <= STEP_X_RST;
         step_y_ff   <= STEP_Y_RST;
         max_iter_ff <= MAX_ITER_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_X_LEFT:   x_left_ff   <= csr_wdata;
            REG_Y_BOTTOM: y_bottom_ff <= csr_wdata;
            REG_STEP_X:   step_x_ff   <= csr_wdata;
            REG_STEP_Y:   step_y_ff   <= csr_wdata;
            REG_MAX_ITER: max_iter_ff <= csr_wdata[ITER_BITS-1:0];
            default: ;
         endcase
      end
   end

   // c: index times step, then add the origin
   always_ff @(posedge clock) begin
      prod_x_ff <= $signed({1'b0, col_ff}) * step_x_ff;
      prod_y_ff <= $signed({1'b0, row_ff}) * step_y_ff;
      cr_ff <= $signed({{(Z_BITS-COORD_BITS){x_left_ff[COORD_BITS-1]}}, x_left_ff}) +
               $signed({{(Z_BITS-MP_BITS){prod_x_ff[MP_BITS-1]}}, prod_x_ff});
      ci_ff <= $signed({{(Z_BITS-COORD_BITS){y_bottom_ff[COORD_BITS-1]}}, y_bottom_ff}) +
               $signed({{(Z_BITS-MP_BITS){prod_y_ff[MP_BITS-1]}}, prod_y_ff});
      col_ff <= col_in;
      row_ff <= row_in;
   end

   // sequencer state and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_count_ff  <= rsp_count_in;
      rsp_inside_ff <= rsp_inside_in;
   end

   // next state, seed and result
   always_comb begin
      state_in      = state_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      seed          = 1'b0;
      rsp_valid_in  = 1'b0;
      rsp_count_in  = ring_out.in_set ? '0 : ring_out.count;
      rsp_inside_in = ring_out.in_set;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               col_in   = req_column;
               row_in   = req_row;
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            state_in = ST_SEED;
         end
         ST_SEED: begin
            seed     = 1'b1;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (ring_out.valid && ring_out.done) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ring input: a fresh word, or the token coming around
   always_comb begin
      seed_tok       = '0;
      seed_tok.valid = 1'b1;
      if (seed) begin
         tok[0] = seed_tok;
      end else if (ring_out.valid && !ring_out.done) begin
         tok[0] = ring_out;
      end else begin
         tok[0] = '0;
      end
   end

   // ring of iteration cells
   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      mbe_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .limit   (max_iter_ff),
         .cr      (cr_ff),
         .ci      (ci_ff),
         .tok_in  (tok[k]),
         .tok_out (tok[k+1])
      );
   end

   assign ring_out = tok[NUM_CELLS];

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_inside_res = rsp_inside_ff;

endmodule

FILE: design/mbe_checker.sv
// ---------------------------------------------------------------------------
// mbe_checker: port-level checks of the escape-time engine
// watches the request and result ports over time
// ---------------------------------------------------------------------------
module mbe_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_valid,
   input logic [mbe_pkg::ITER_BITS-1:0]     rsp_count,
   input logic                              rsp_inside_res
);
   import mbe_pkg::*;

   // an accepted word keeps the engine busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("engine not busy after accepting a word");

   // a result comes only at the end of a busy period
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) && !busy))
      else $error("result outside the end of a busy period");

   // a result shows for one cycle only
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // an inside point reports a zero count
   a_inside_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_inside_res) |-> (rsp_count == '0))
      else $error("inside point with nonzero count");

endmodule

bind mandelbrot_escape_time mbe_checker u_mbe_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_count      (rsp_count),
   .rsp_inside_res (rsp_inside_res)
);

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for the mandelbrot escape-time engine
// drives pixel indexes through the start/busy port under several viewing
// windows and iteration limits, predicts each escape count in fixed point
// and compares every result strobe against the oldest prediction
// ---------------------------------------------------------------------------
module testbench;
   import mbe_pkg::*;

   localparam int  RANDOM_ITEMS = 1535;
   localparam int  CALM_TAIL    = 200;
   localparam int  SETTLE_CYCLES = 8;
   localparam int  FIX_ONE      = 1 << FRAC_BITS;
   localparam int  FIX_QUARTER  = FIX_ONE / 4;
   localparam int  FIX_THREE    = 3 * FIX_ONE;
   localparam int  COORD_MIN    = 32'sh8000_0000;
   localparam int  COORD_MAX    = 32'sh7FFF_FFFF;
   localparam int  ITER_MAX     = (1 << ITER_BITS) - 1;
   localparam int  INDEX_MAX    = (1 << INDEX_BITS) - 1;
   localparam int  CSR_IDX_TOP  = (1 << CSR_IDX_BITS) - 1;

   typedef struct packed {
      logic [ITER_BITS-1:0] count;
      logic                 in_set;
   } escape_word_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x_left;
      logic signed [COORD_BITS-1:0] y_bottom;
      logic signed [COORD_BITS-1:0] step_x;
      logic signed [COORD_BITS-1:0] step_y;
      logic [ITER_BITS-1:0]         max_iter;
   } view_type;

   // scoreboard: mirror of the registers plus the escape-time predictor
   class escape_scoreboard;
      logic signed [COORD_BITS-1:0] x_left;
      logic signed [COORD_BITS-1:0] y_bottom;
      logic signed [COORD_BITS-1:0] step_x;
      logic signed [COORD_BITS-1:0] step_y;
      logic [ITER_BITS-1:0]         max_iter;
      escape_word_type              expected_escapes[$];
      int                           errors;
      int                           pixels;
      int                           inside_pixels;
      int                           deepest;

      function new();
         x_left   = X_LEFT_RST;
         y_bottom = Y_BOTTOM_RST;
         step_x   = STEP_X_RST;
         step_y   = STEP_Y_RST;
         max_iter = MAX_ITER_RST;
         errors = 0;
         pixels = 0;
         inside_pixels = 0;
         deepest = 0;
      endfunction

      function void write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                              input logic [CSR_DATA_BITS-1:0] data);
         case (idx)
            REG_X_LEFT:   x_left   = data;
            REG_Y_BOTTOM: y_bottom = data;
            REG_STEP_X:   step_x   = data;
            REG_STEP_Y:   step_y   = data;
            REG_MAX_ITER: max_iter = data[ITER_BITS-1:0];
            default: ;
         endcase
      endfunction

      // magnitude product shifted right, truncated toward zero, sign restored
      function longint fix_mul(input longint a, input longint b, input int shift);
         longint unsigned ma;
         longint unsigned mb;
         longint unsigned p;
         ma = (a < 0) ? -a : a;
         mb = (b < 0) ? -b : b;
         p = (ma * mb) >> shift;
         return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
      endfunction

      function escape_word_type escape_time(input logic [INDEX_BITS-1:0] col,
                                            input logic [INDEX_BITS-1:0] row);
         longint          cr;
         longint          ci;
         longint          zr;
         longint          zi;
         longint          sr;
         longint          si;
         longint          nr;
         longint          two;
         longint          four;
         int unsigned     n;
         escape_word_type w;
         cr = longint'(x_left) + longint'(col) * longint'(step_x);
         ci = longint'(y_bottom) + longint'(row) * longint'(step_y);
         two  = longint'(1) << (FRAC_BITS + 1);
         four = longint'(1) << (FRAC_BITS + 2);
         zr = 0;
         zi = 0;
         n = 0;
         while (n < max_iter) begin
            // a component of 2.0 or more has escaped without squaring
            if (zr >= two || zr <= -two || zi >= two || zi <= -two) break;
            sr = fix_mul(zr, zr, FRAC_BITS);
            si = fix_mul(zi, zi, FRAC_BITS);
            if (sr + si >= four) break;
            nr = sr - si + cr;
            zi = fix_mul(zr, zi, FRAC_BITS - 1) + ci;
            zr = nr;
            n++;
         end
         // reaching the limit, even on the escaping iteration, means inside
         if (n < max_iter) begin
            w.count  = n[ITER_BITS-1:0];
            w.in_set = 1'b0;
         end else begin
            w.count  = '0;
            w.in_set = 1'b1;
         end
         return w;
      endfunction

      function void note_pixel(input logic [INDEX_BITS-1:0] col,
                               input logic [INDEX_BITS-1:0] row);
         escape_word_type w;
         w = escape_time(col, row);
         expected_escapes.push_back(w);
         pixels++;
         if (w.in_set) inside_pixels++;
         if (int'(w.count) > deepest) deepest = int'(w.count);
      endfunction

      function void check_result(input logic [ITER_BITS-1:0] count, input logic in_set);
         escape_word_type w;
         if (expected_escapes.size() == 0) begin
            $error("unexpected result word: count %0d inside_res %0d", count, in_set);
            errors++;
            return;
         end
         w = expected_escapes.pop_front();
         if (count !== w.count) begin
            $error("count: expected %0d, actual %0d", w.count, count);
            errors++;
         end
         if (in_set !== w.in_set) begin
            $error("inside_res: expected %0d, actual %0d", w.in_set, in_set);
            errors++;
         end
      endfunction

      function int pending();
         return expected_escapes.size();
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [INDEX_BITS-1:0]     req_column = '0;
   logic [INDEX_BITS-1:0]     req_row = '0;
   logic                      rsp_valid;
   logic [ITER_BITS-1:0]      rsp_count;
   logic                      rsp_inside_res;
   logic                      csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0]   csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   escape_scoreboard sb = new();
   bit               idling = 1'b0;
   int               settings_used = 1;

   mandelbrot_escape_time DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_column     (req_column),
      .req_row        (req_row),
      .rsp_valid      (rsp_valid),
      .rsp_count      (rsp_count),
      .rsp_inside_res (rsp_inside_res),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #1 clock = ~clock;

   // result monitor: each strobe is one word, taken at the edge ending it
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1)
         sb.check_result(rsp_count, rsp_inside_res);
   end

   // one pixel: optional idle burst, then hold start until busy is low
   task automatic send_pixel(input int unsigned col, input int unsigned row);
      int unsigned gap;
      if (idling && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 16);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start      <= 1'b1;
      req_column <= INDEX_BITS'(col);
      req_row    <= INDEX_BITS'(row);
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      sb.note_pixel(INDEX_BITS'(col), INDEX_BITS'(row));
   endtask

   // stop issuing and wait for the engine to go quiet
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0 || busy !== 1'b0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   // write a whole view; junk adds a write to an unused index and dirty
   // upper bits on the limit register
   task automatic load_view(input view_type v, input bit junk);
      logic [CSR_IDX_BITS-1:0] spare;
      logic [15:0]             pad;
      pad = junk ? 16'($urandom()) : '0;
      if (junk) begin
         spare = CSR_IDX_BITS'($urandom_range(int'(REG_MAX_ITER) + 1, CSR_IDX_TOP));
         csr_write(spare, $urandom());
      end
      csr_write(REG_X_LEFT, v.x_left);
      csr_write(REG_Y_BOTTOM, v.y_bottom);
      csr_write(REG_STEP_X, v.step_x);
      csr_write(REG_STEP_Y, v.step_y);
      csr_write(REG_MAX_ITER, {pad, v.max_iter});
      csr_we <= 1'b0;
      settings_used++;
   endtask

   function automatic view_type make_view(input int xl, input int yb, input int sx,
                                          input int sy, input int mi);
      view_type v;
      v.x_left   = xl;
      v.y_bottom = yb;
      v.step_x   = sx;
      v.step_y   = sy;
      v.max_iter = mi[ITER_BITS-1:0];
      return v;
   endfunction

   function automatic int random_step(input int unsigned span);
      int s;
      s = int'($urandom_range(0, span));
      return ($urandom_range(0, 1) == 1) ? -s : s;
   endfunction

   // random view: mostly a window over the set, some wild, some zoomed in
   function automatic view_type random_view();
      view_type    v;
      int unsigned kind;
      int unsigned pick;
      kind = $urandom_range(0, 9);
      if (kind < 7 || kind == 9) begin
         v.x_left   = int'($urandom_range(0, 7 * FIX_ONE / 2)) - 5 * FIX_ONE / 2;
         v.y_bottom = int'($urandom_range(0, 3 * FIX_ONE)) - 3 * FIX_ONE / 2;
         v.step_x   = random_step(kind == 9 ? 255 : 131072);
         v.step_y   = random_step(kind == 9 ? 255 : 131072);
      end else begin
         v.x_left   = $urandom();
         v.y_bottom = $urandom();
         v.step_x   = $urandom();
         v.step_y   = $urandom();
      end
      pick = $urandom_range(0, 19);
      if (pick < 15)
         v.max_iter = ITER_BITS'($urandom_range(1, 48));
      else if (pick < 18)
         v.max_iter = MAX_ITER_RST;
      else
         v.max_iter = ITER_BITS'($urandom_range(1, 512));
      return v;
   endfunction

   // stimulus
   initial begin
      int sent;
      int phase_len;
      bit phase_idle;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset view: index corners and one interior point near (-1.5, -1.125)
      idling = 1'b1;
      send_pixel(0, 0);
      send_pixel(INDEX_MAX, INDEX_MAX);
      send_pixel(INDEX_MAX, 0);
      send_pixel(0, INDEX_MAX);
      send_pixel(170, 128);

      // escape on the last allowed iteration still reads as inside
      drain();
      load_view(make_view(FIX_THREE, 0, 0, 0, 1), 1'b1);
      send_pixel(1234, 2345);
      drain();
      load_view(make_view(FIX_THREE, 0, 0, 0, 2), 1'b0);
      send_pixel(INDEX_MAX, 0);
      // zero limit: no iteration at all
      drain();
      load_view(make_view(FIX_THREE, 0, 0, 0, 0), 1'b1);
      send_pixel(7, 9);

      // coordinate extremes with the largest limit
      drain();
      load_view(make_view(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, ITER_MAX), 1'b0);
      send_pixel(0, 0);
      send_pixel(INDEX_MAX, INDEX_MAX);
      drain();
      load_view(make_view(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, ITER_MAX), 1'b0);
      send_pixel(INDEX_MAX, 0);
      send_pixel(0, INDEX_MAX);

      // slow points at the cusp: full-limit inside and very late escapes
      drain();
      load_view(make_view(FIX_QUARTER, 0, 1, 0, ITER_MAX), 1'b0);
      send_pixel(0, 0);
      send_pixel(3, 0);
      send_pixel(INDEX_MAX, INDEX_MAX);

      // random phases, each under its own view
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         drain();
         load_view(random_view(), $urandom_range(0, 3) == 0);
         phase_len = $urandom_range(20, 80);
         phase_idle = ($urandom_range(0, 3) != 0);
         for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
            idling = phase_idle && (sent < RANDOM_ITEMS - CALM_TAIL);
            send_pixel($urandom_range(0, INDEX_MAX), $urandom_range(0, INDEX_MAX));
            sent++;
         end
      end

      drain();
      if (sb.pending() != 0) begin
         $error("%0d expected result words never arrived", sb.pending());
         sb.errors++;
      end
      $display("%0d pixels under %0d register settings, %0d of them inside",
               sb.pixels, settings_used, sb.inside_pixels);
      $display("deepest escape seen after %0d iterations", sb.deepest);
      if (sb.errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
